/* design/ibma_pkg.sv */
// Shared types, constants and helpers for the id bitmap allocator.
`default_nettype none
package ibma_pkg;

	localparam int ID_CAPACITY = 4096;
	localparam int ROW_BITS    = 64;
	localparam int MAP_ROWS    = ID_CAPACITY / ROW_BITS;
	localparam int ROW_AW      = $clog2(MAP_ROWS);
	localparam int BIT_AW      = $clog2(ROW_BITS);
	localparam int SLOT_W      = ROW_AW + BIT_AW;
	localparam int COUNT_W     = 13;
	localparam int ID_W        = 16;
	localparam int STATUS_W    = 2;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_PAD_W   = OUT_TDATA_W - ID_W - STATUS_W;

	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam logic [ID_W-1:0]    LOWEST_ID_RESET = 16'd300;
	localparam logic [COUNT_W-1:0] ID_COUNT_RESET  = 13'd2701;
	localparam logic [COUNT_W-1:0] CAPACITY_COUNT  = COUNT_W'(ID_CAPACITY);

	// Register indexes, taken from paddr[2]
	localparam logic REG_LOWEST_ID = 1'b0;
	localparam logic REG_ID_COUNT  = 1'b1;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_RANGE     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ES_IDLE,
		ES_DECODE,
		ES_SCAN,
		ES_REL,
		ES_DONE
	} eng_state_t;

	typedef struct packed {
		op_t             op;
		logic [ID_W-1:0] rid;
	} req_t;

	typedef struct packed {
		status_t         status;
		logic [ID_W-1:0] granted_id;
	} res_t;

	typedef struct packed {
		logic              found;
		logic [BIT_AW-1:0] index;
	} zero_hit_t;

	// Lowest clear bit of a map row
	function automatic zero_hit_t first_zero(input logic [ROW_BITS-1:0] row);
		zero_hit_t h;
		h.found = 1'b0;
		h.index = '0;
		for (int i = ROW_BITS - 1; i >= 0; i--) begin
			if (!row[i]) begin
				h.found = 1'b1;
				h.index = BIT_AW'(i);
			end
		end
		return h;
	endfunction

endpackage
`default_nettype wire

/* design/ibma_map_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ibma_map_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* design/ibma_cfg_regs.sv */
// APB register file for lowest_id and id_count, plus the effective count.
`default_nettype none
module ibma_cfg_regs
	import ibma_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output logic      [ID_W-1:0]   lowest_id,
	output logic      [COUNT_W-1:0] eff_count
);

	logic [ID_W-1:0]    lowest_id_q;
	logic [COUNT_W-1:0] id_count_q;
	logic               wr_en;
	logic [ID_W:0]      room;
	logic [COUNT_W-1:0] capped;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_id_q <= LOWEST_ID_RESET;
			id_count_q  <= ID_COUNT_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_LOWEST_ID: lowest_id_q <= pwdata[ID_W-1:0];
				REG_ID_COUNT:  id_count_q  <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LOWEST_ID: prdata = APB_DW'(lowest_id_q);
			REG_ID_COUNT:  prdata = APB_DW'(id_count_q);
			default:       prdata = '0;
		endcase
	end

	// Saturate to the map capacity and to the ids left below 2^16
	assign room   = (ID_W+1)'(1 << ID_W) - {1'b0, lowest_id_q};
	assign capped = (id_count_q > CAPACITY_COUNT) ? CAPACITY_COUNT : id_count_q;

	always_comb begin
		if (room < (ID_W+1)'(capped)) begin
			eff_count = room[COUNT_W-1:0];
		end else begin
			eff_count = capped;
		end
	end

	assign lowest_id = lowest_id_q;

endmodule
`default_nettype wire

/* design/ibma_engine.sv */
// Request engine: scans and updates the used-bit map held in RAM.
`default_nettype none
module ibma_engine
	import ibma_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire req_t               req,
	output logic                    ready,
	input  wire logic [ID_W-1:0]    lowest_id,
	input  wire logic [COUNT_W-1:0] eff_count,
	output logic                    res_valid,
	output res_t                    res,
	input  wire logic               res_ready
);

	eng_state_t          state_q, state_d;
	op_t                 op_q;
	logic [ID_W-1:0]     rid_q;
	logic [ROW_AW-1:0]   row_q, row_d;
	logic [BIT_AW-1:0]   bit_q, bit_d;
	res_t                res_q, res_d;
	logic [MAP_ROWS-1:0] row_valid_q;

	logic                mem_we;
	logic [ROW_BITS-1:0] mem_wdata;
	logic [ROW_AW-1:0]   rd_addr;
	logic [ROW_BITS-1:0] rdata;
	logic [ROW_BITS-1:0] row_data;
	zero_hit_t           hit;
	logic [SLOT_W-1:0]   slot;
	logic [COUNT_W-1:0]  next_base;
	logic [ID_W:0]       rel_off;
	logic                rel_ok;

	ibma_map_ram #(
		.DEPTH(MAP_ROWS),
		.WIDTH(ROW_BITS)
	) u_map_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(row_q),
		.wdata(mem_wdata),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// A row never written reads as all free
	assign row_data  = row_valid_q[row_q] ? rdata : '0;
	assign hit       = first_zero(row_data);
	assign slot      = {row_q, hit.index};
	assign next_base = COUNT_W'(({1'b0, row_q} + 1'b1)) << BIT_AW;
	assign rel_off   = {1'b0, rid_q} - {1'b0, lowest_id};
	assign rel_ok    = (rid_q >= lowest_id) && (rel_off < (ID_W+1)'(eff_count));

	always_comb begin
		state_d   = state_q;
		row_d     = row_q;
		bit_d     = bit_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_wdata = row_data;
		rd_addr   = row_q + 1'b1;
		ready     = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ES_IDLE: begin
				ready = 1'b1;
				if (start) begin
					state_d = ES_DECODE;
				end
			end
			ES_DECODE: begin
				if (op_q == OP_ALLOC) begin
					rd_addr = '0;
					row_d   = '0;
					if (eff_count == '0) begin
						res_d   = '{status: ST_EXHAUSTED, granted_id: '0};
						state_d = ES_DONE;
					end else begin
						state_d = ES_SCAN;
					end
				end else begin
					rd_addr = rel_off[SLOT_W-1:BIT_AW];
					row_d   = rel_off[SLOT_W-1:BIT_AW];
					bit_d   = rel_off[BIT_AW-1:0];
					if (rel_ok) begin
						state_d = ES_REL;
					end else begin
						res_d   = '{status: ST_RANGE, granted_id: rid_q};
						state_d = ES_DONE;
					end
				end
			end
			ES_SCAN: begin
				if (hit.found) begin
					state_d = ES_DONE;
					if (COUNT_W'(slot) < eff_count) begin
						mem_we    = 1'b1;
						mem_wdata = row_data | (ROW_BITS'(1) << hit.index);
						res_d     = '{status: ST_OK,
							granted_id: lowest_id + ID_W'(slot)};
					end else begin
						res_d = '{status: ST_EXHAUSTED, granted_id: '0};
					end
				end else if (next_base >= eff_count) begin
					res_d   = '{status: ST_EXHAUSTED, granted_id: '0};
					state_d = ES_DONE;
				end else begin
					// advance; the read of the next row is already issued
					row_d = row_q + 1'b1;
				end
			end
			ES_REL: begin
				mem_we    = 1'b1;
				mem_wdata = row_data & ~(ROW_BITS'(1) << bit_q);
				res_d     = '{status: ST_OK, granted_id: rid_q};
				state_d   = ES_DONE;
			end
			ES_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ES_IDLE;
				end
			end
			default: state_d = ES_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ES_IDLE;
			row_valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				row_valid_q[row_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && ready) begin
			op_q  <= req.op;
			rid_q <= req.rid;
		end
		row_q <= row_d;
		bit_q <= bit_d;
		res_q <= res_d;
	end

	assign res = res_q;

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ES_SCAN || state_q == ES_REL))
		else $error("map written outside scan or release");

	a_row_marked: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> row_valid_q[$past(row_q)])
		else $error("written row not marked valid");

	a_exhausted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_EXHAUSTED) |-> (res.granted_id == '0))
		else $error("exhausted result carries an id");

	a_release_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && op_q == OP_RELEASE) |-> (res.granted_id == rid_q
			&& res.status != ST_EXHAUSTED))
		else $error("release result does not echo its id");

endmodule
`default_nettype wire

/* design/id_bitmap_allocator_unit.sv */
// Top level of the id bitmap allocator: stream ports, registers, output stage.
//
// Allocates ids from a used-bit map of 4096 slots. Slot k stands for id
// lowest_id + k; only slots below the effective count (id_count capped to
// 4096 and to the ids left below 65536) take part.
// Input stream: s_tuser[0] is the request kind (0 allocate, 1 release),
// s_tdata[15:0] the id to release. Output stream: m_tdata[1:0] status
// (0 ok, 1 no free id, 2 release id out of range), m_tdata[17:2] the id.
// The APB port holds lowest_id at 0x0 and id_count at 0x4; write them only
// while no request is in flight.
// The map sits in a 64 x 64-bit RAM with registered read data. An
// allocate reads one row per cycle until it meets a clear bit or runs
// past the effective count. A release reads, clears and writes back
// one row. An allocate under a zero count and a release of an id out
// of range skip the map. One request is in work at a time; the next
// is taken as soon as the previous result sits in the output register,
// even while the receiver stalls it. Reset marks every row unwritten
// through per-row valid flags, so all ids are free at once with no
// clearing pass; registers return to lowest_id 300 and id_count 2701.
`default_nettype none
module id_bitmap_allocator_unit
	import ibma_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [ID_W-1:0]        s_tdata,   // [15:0] release_id
	input  wire logic [0:0]             s_tuser,   // [0] operation
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic      [OUT_TDATA_W-1:0] m_tdata,   // [1:0] status, [17:2] granted_id
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [APB_AW-1:0]      paddr,
	input  wire logic [APB_DW-1:0]      pwdata,
	output logic      [APB_DW-1:0]      prdata,
	output logic                        pready
);

	logic [ID_W-1:0]    lowest_id;
	logic [COUNT_W-1:0] eff_count;
	req_t               req;
	logic               eng_ready;
	logic               res_valid;
	logic               res_ready;
	res_t               res;
	logic               out_valid_q;
	res_t               out_q;

	ibma_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.lowest_id(lowest_id),
		.eff_count(eff_count)
	);

	// Unpack the request
	assign req.op  = op_t'(s_tuser[0]);
	assign req.rid = s_tdata;

	assign s_tready = eng_ready;

	ibma_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_tvalid),
		.req      (req),
		.ready    (eng_ready),
		.lowest_id(lowest_id),
		.eff_count(eff_count),
		.res_valid(res_valid),
		.res      (res),
		.res_ready(res_ready)
	);

	// Output register: take a new result when empty or being drained
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// Hold the payload while the receiver stalls
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {OUT_PAD_W'(0), out_q.granted_id, out_q.status};

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Testbench for the id bitmap allocator: directed and random requests checked against a local map.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ibma_pkg::*;

	// A stretch this long with no handshake and no register access means the block hung.
	// The longest legal quiet stretch is the receiver hold-off plus one full scan.
	localparam int QUIET_LIMIT   = 4000;
	localparam int HOLD_OFF      = 300;
	localparam int SETTLE_CYCLES = 80;
	localparam int IDLE_PERCENT  = 22;
	localparam int SHOWN_ERRORS  = 10;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [ID_W-1:0]        s_tdata;   // [15:0] release_id
	logic [0:0]             s_tuser;   // [0] operation
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // [1:0] status, [17:2] granted_id
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_AW-1:0]      paddr;
	logic [APB_DW-1:0]      pwdata;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;

	id_bitmap_allocator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Local copy of the id map and of the two registers, as the block should hold them.
	bit              slot_taken [ID_CAPACITY];
	logic [ID_W-1:0] cfg_lowest;
	logic [12:0]     cfg_count;

	// Replies the block owes, oldest first.
	res_t pending_replies [$];

	// Run statistics and error bookkeeping.
	int   grants_made;
	int   exhaustions;
	int   releases_done;
	int   range_rejects;
	int   settings_used;
	int   replies_checked;
	int   mismatches;
	int   quiet_cycles;

	// Idling controls shared with the receiver process.
	bit   steady;
	int   stall_left;

	// Clock: 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Number of slots that take part: id_count capped to the map size and to the ids
	// left below 65536, so a granted id never wraps.
	function automatic int unsigned usable_slots();
		int unsigned n;
		int unsigned room;
		n    = cfg_count;
		room = 32'd65536 - cfg_lowest;
		if (n > ID_CAPACITY)
			n = ID_CAPACITY;
		if (n > room)
			n = room;
		return n;
	endfunction

	// Apply one request to the local map and return the reply the block must give.
	function automatic res_t resolve_request(op_t op, logic [ID_W-1:0] rid);
		res_t        r;
		int unsigned n;
		int unsigned slot;
		int unsigned id_u;
		n = usable_slots();
		if (op == OP_ALLOC) begin
			slot = 0;
			while (slot < n && slot_taken[slot])
				slot++;
			if (slot >= n) begin
				// Exhausted: granted id reads as zero.
				r.status     = ST_EXHAUSTED;
				r.granted_id = '0;
				exhaustions++;
			end else begin
				slot_taken[slot] = 1'b1;
				r.status         = ST_OK;
				r.granted_id     = ID_W'(cfg_lowest + slot);
				grants_made++;
			end
		end else begin
			// Release echoes the id whatever the outcome; freeing a free id is harmless.
			id_u         = rid;
			r.granted_id = rid;
			if (id_u < cfg_lowest || id_u - cfg_lowest >= n) begin
				r.status = ST_RANGE;
				range_rejects++;
			end else begin
				slot_taken[id_u - cfg_lowest] = 1'b0;
				r.status                      = ST_OK;
				releases_done++;
			end
		end
		return r;
	endfunction

	// Offer one request, idling the sender at random first, and log the reply it owes
	// once the block takes it.
	task automatic send_request(op_t op, logic [ID_W-1:0] rid);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= rid;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_replies.push_back(resolve_request(op, rid));
	endtask

	// Drop valid and hold until every owed reply has come back.
	task automatic wait_for_replies();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	// One APB write: setup cycle, then access cycle; pready is always high.
	task automatic write_register(logic idx, logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_LOWEST_ID)
			cfg_lowest = value[ID_W-1:0];
		else
			cfg_count = value[12:0];
		@(posedge clk);
	endtask

	// Change both registers once the block is idle; upper bits of the words are
	// don't-care and must be dropped by the block.
	task automatic set_config(logic [APB_DW-1:0] lowest_word, logic [APB_DW-1:0] count_word);
		wait_for_replies();
		write_register(REG_LOWEST_ID, lowest_word);
		write_register(REG_ID_COUNT, count_word);
		settings_used++;
	endtask

	// Reset values: lowest 300, count 2701.
	task automatic test_default_registers();
		send_request(OP_ALLOC, 16'hFFFF);
		send_request(OP_ALLOC, 16'h0000);
		send_request(OP_RELEASE, 16'd300);
		send_request(OP_ALLOC, 16'h1234);
		send_request(OP_RELEASE, 16'd299);
		send_request(OP_RELEASE, 16'd3001);
		send_request(OP_RELEASE, 16'd3000);
	endtask

	// Fill a three-id range and hit exhaustion, then release id 3, just past the range.
	task automatic test_exhaustion();
		set_config(32'd0, 32'd3);
		send_request(OP_RELEASE, 16'd0);
		send_request(OP_RELEASE, 16'd1);
		send_request(OP_ALLOC, 16'd0);
		send_request(OP_ALLOC, 16'd0);
		send_request(OP_ALLOC, 16'd0);
		send_request(OP_ALLOC, 16'd0);
		send_request(OP_RELEASE, 16'd3);
	endtask

	// A count write of 8192 truncates to zero: nothing to grant, nothing to release.
	task automatic test_zero_count();
		set_config(32'd500, 32'h0000_2000);
		send_request(OP_ALLOC, 16'd500);
		send_request(OP_RELEASE, 16'd500);
	endtask

	// Top of the id space limits the range; a large count saturates to the map size.
	task automatic test_id_space_top();
		set_config(32'hABCD_FFFF, 32'd4096);
		send_request(OP_RELEASE, 16'hFFFF);
		send_request(OP_ALLOC, 16'd0);
		send_request(OP_ALLOC, 16'd0);
		set_config(32'd0, 32'h0000_1FFF);
		send_request(OP_RELEASE, 16'd4095);
		send_request(OP_RELEASE, 16'd4096);
	endtask

	// Shrinking the count hides used slots; growing it brings them back.
	task automatic test_count_shrink();
		set_config(32'd1000, 32'd4);
		send_request(OP_ALLOC, 16'd0);
		send_request(OP_ALLOC, 16'd0);
		set_config(32'd1000, 32'd2);
		send_request(OP_RELEASE, 16'd1003);
		send_request(OP_ALLOC, 16'd0);
		set_config(32'd1000, 32'd4);
		send_request(OP_RELEASE, 16'd1003);
		send_request(OP_ALLOC, 16'd0);
	endtask

	// One request drawn from the current range: mostly allocate and release of ids in
	// range, some edges of the range, some arbitrary ids.
	task automatic send_mixed_request();
		int unsigned n;
		int unsigned pick;
		int unsigned which;
		logic [ID_W-1:0] rid;
		n    = usable_slots();
		pick = $urandom_range(99);
		rid  = ID_W'($urandom);
		if (pick < 48) begin
			send_request(OP_ALLOC, rid);
		end else if (pick < 80 && n > 0) begin
			send_request(OP_RELEASE, ID_W'(cfg_lowest + $urandom_range(n - 1)));
		end else if (pick < 90 && n > 0) begin
			which = $urandom_range(3);
			case (which)
				0: rid = ID_W'(cfg_lowest - 1);
				1: rid = ID_W'(cfg_lowest + n);
				2: rid = ID_W'(cfg_lowest + n - 1);
				default: rid = cfg_lowest;
			endcase
			send_request(OP_RELEASE, rid);
		end else begin
			send_request(OP_RELEASE, rid);
		end
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering, so the
	// block backs up and stalls its input; then the sender pauses until all is back.
	task automatic test_back_pressure();
		set_config(32'd2000, 32'd48);
		stall_left = HOLD_OFF;
		repeat (40)
			send_mixed_request();
		wait_for_replies();
	endtask

	// No idling on either side: requests back to back.
	task automatic test_steady_stream();
		set_config(32'd40000, 32'd24);
		steady = 1'b1;
		repeat (150)
			send_mixed_request();
		wait_for_replies();
		steady = 1'b0;
	endtask

	// Random register settings, mostly small ranges so exhaustion and reuse happen often.
	task automatic test_random_traffic(int phases);
		int unsigned kind;
		logic [15:0] lowest;
		logic [12:0] count;
		repeat (phases) begin
			kind   = $urandom_range(99);
			lowest = 16'($urandom_range(61440));
			count  = 13'($urandom_range(1, 64));
			if (kind < 10) begin
				lowest = 16'(65535 - $urandom_range(40));
				if ($urandom_range(1))
					count = 13'd4096;
			end else if (kind < 15) begin
				count = 13'd0;
			end else if (kind < 25) begin
				count = $urandom_range(1) ? 13'h1FFF : 13'($urandom_range(65, 4096));
			end
			set_config({16'($urandom), lowest}, {19'($urandom), count});
			repeat ($urandom_range(40, 80))
				send_mixed_request();
		end
		wait_for_replies();
	endtask

	// Receiver: random stalls, none in steady stretches, all-stall during a hold-off.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Reply checker: compare each reply taken with the oldest one owed.
	always @(posedge clk) begin
		res_t            want;
		logic [1:0]      got_status;
		logic [ID_W-1:0] got_id;
		if (arst_n && m_tvalid && m_tready) begin
			got_status = m_tdata[1:0];
			got_id     = m_tdata[17:2];
			replies_checked++;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_ERRORS)
					$display("reply %0d with none owed: status %0d id %0d",
						replies_checked, got_status, got_id);
			end else begin
				want = pending_replies.pop_front();
				if (got_status !== want.status || got_id !== want.granted_id) begin
					mismatches++;
					if (mismatches <= SHOWN_ERRORS)
						$display("reply %0d: expected status %0d id %0d, got status %0d id %0d",
							replies_checked, want.status, want.granted_id, got_status, got_id);
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("id_bitmap_allocator_unit regression: fail");
			$finish;
		end
	end

	initial begin
		// Drive every input to a known value before the first edge.
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		m_tready   = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		steady     = 1'b0;
		stall_left = 0;
		cfg_lowest = LOWEST_ID_RESET;
		cfg_count  = ID_COUNT_RESET;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_registers();
		test_exhaustion();
		test_zero_count();
		test_id_space_top();
		test_count_shrink();
		test_back_pressure();
		test_steady_stream();
		test_random_traffic(17);

		// Drain, then give the block a full scan's time to show any stray reply.
		wait_for_replies();
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		$display("covered %0d register settings: %0d grants, %0d exhausted, %0d releases, %0d out of range",
			settings_used, grants_made, exhaustions, releases_done, range_rejects);
		$display("checked %0d replies, %0d mismatches, %0d still owed",
			replies_checked, mismatches, pending_replies.size());
		if (mismatches == 0 && pending_replies.size() == 0)
			$display("id_bitmap_allocator_unit regression: pass");
		else
			$display("id_bitmap_allocator_unit regression: fail");
		$finish;
	end

endmodule
